// File: rtl/mcur_pkg.sv
`timescale 1ns / 1ps
// Shared constants, request and status codes, and ring status type for the
// multichannel UART ring FIFO block. No dependencies.
package mcur_pkg;

    localparam int NUM_CHANNELS_DEF = 3;
    localparam int RX_DEPTH_DEF     = 64;
    localparam int TX_DEPTH_DEF     = 64;

    localparam int REQ_W    = 3;
    localparam int CH_W     = 2;
    localparam int DATA_W   = 8;
    localparam int COUNT_W  = 6;
    localparam int STATUS_W = 2;
    localparam int LEVEL_W  = 6;

    localparam logic [REQ_W-1:0] REQ_LINE_RX  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_HOST_RD  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_HOST_WR  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_TX_READY = 3'd3;
    localparam logic [REQ_W-1:0] REQ_LEVEL    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_CH = 2'd3;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

    // Status of the addressed ring, as seen by the control logic.
    typedef struct packed {
        logic               full;
        logic               empty;
        logic [LEVEL_W-1:0] level;      // current level, saturated
        logic [LEVEL_W-1:0] level_inc;  // level after one push, saturated
    } t_ring_stat;

endpackage

// File: rtl/mcur_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and responses.
// Depends on mcur_pkg for field widths.
interface mcur_req_if;
    logic                         valid;
    logic                         ready;
    logic [mcur_pkg::REQ_W-1:0]   req_type;
    logic [mcur_pkg::CH_W-1:0]    channel;
    logic [mcur_pkg::DATA_W-1:0]  data_in;
    logic [mcur_pkg::COUNT_W-1:0] count;

    modport source (output valid, req_type, channel, data_in, count, input ready);
    modport sink   (input valid, req_type, channel, data_in, count, output ready);
endinterface

interface mcur_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [mcur_pkg::STATUS_W-1:0] status;
    logic [mcur_pkg::DATA_W-1:0]   data_out;
    logic                          data_valid;
    logic                          last;
    logic [mcur_pkg::LEVEL_W-1:0]  rx_level;
    logic [mcur_pkg::LEVEL_W-1:0]  tx_level;

    modport source (output valid, status, data_out, data_valid, last, rx_level, tx_level,
                    input ready);
    modport sink   (input valid, status, data_out, data_valid, last, rx_level, tx_level,
                    output ready);
endinterface

// File: rtl/mcur_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mcur_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // hold read data until the next read
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/mcur_ring_ptrs.sv
`timescale 1ns / 1ps
// Head and tail pointer bank for one direction of all channels, with full,
// empty and level status for the selected channel. Depends on mcur_pkg.
module mcur_ring_ptrs #(
    parameter int NUM_CHANNELS = mcur_pkg::NUM_CHANNELS_DEF,
    parameter int DEPTH        = mcur_pkg::RX_DEPTH_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic [(NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1)-1:0] i_ch,
    input  logic                                          i_push,
    input  logic                                          i_pop,
    output logic [$clog2(DEPTH)-1:0]                      o_head_nxt,
    output logic [$clog2(DEPTH)-1:0]                      o_tail_nxt,
    output mcur_pkg::t_ring_stat                          o_stat
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = (AW > mcur_pkg::LEVEL_W) ? AW : mcur_pkg::LEVEL_W;

    logic [AW-1:0] r_head [NUM_CHANNELS];
    logic [AW-1:0] r_tail [NUM_CHANNELS];

    logic [AW-1:0] head;
    logic [AW-1:0] tail;
    logic [AW-1:0] lvl;
    logic [AW-1:0] lvl_inc;
    logic [LW-1:0] lvl_ext;
    logic [LW-1:0] lvl_inc_ext;

    assign head       = r_head[i_ch];
    assign tail       = r_tail[i_ch];
    assign o_head_nxt = head + AW'(1);
    assign o_tail_nxt = tail + AW'(1);

    assign lvl         = head - tail;
    assign lvl_inc     = lvl + AW'(1);
    assign lvl_ext     = LW'(lvl);
    assign lvl_inc_ext = LW'(lvl_inc);

    always_comb begin
        o_stat.full      = (o_head_nxt == tail);
        o_stat.empty     = (head == tail);
        o_stat.level     = (lvl_ext > LW'(mcur_pkg::LEVEL_MAX)) ? mcur_pkg::LEVEL_MAX
                                                                : lvl_ext[mcur_pkg::LEVEL_W-1:0];
        o_stat.level_inc = (lvl_inc_ext > LW'(mcur_pkg::LEVEL_MAX)) ? mcur_pkg::LEVEL_MAX
                                                                : lvl_inc_ext[mcur_pkg::LEVEL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
            end
        end else begin
            // advance the selected pointer
            if (i_push) begin
                r_head[i_ch] <= o_head_nxt;
            end
            if (i_pop) begin
                r_tail[i_ch] <= o_tail_nxt;
            end
        end
    end

endmodule

// File: rtl/multichannel_uart_ring_fifos_core.sv
`timescale 1ns / 1ps
// Multichannel UART ring FIFOs: per-channel receive and transmit byte rings.
// A push, a level query, a rejected or empty request loads its result into the output
// register on acceptance; a pop reads its first byte into the RAM output register, then
// the output register when it frees up. A host read gives one byte per cycle once begun,
// unless the output stalls; a new request waits for idle and a free output register.
// Reset clears all pointers at once; the byte stores are not cleared, no clearing pass.
module multichannel_uart_ring_fifos_core #(
    parameter int NUM_CHANNELS = mcur_pkg::NUM_CHANNELS_DEF,
    parameter int RX_DEPTH     = mcur_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH     = mcur_pkg::TX_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mcur_req_if.sink   i_req,
    mcur_rsp_if.source o_rsp
);

    // Widths derived from the channel count and ring depths.
    localparam int CW        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int RX_AW     = $clog2(RX_DEPTH);
    localparam int TX_AW     = $clog2(TX_DEPTH);
    localparam int RX_MEM_D  = NUM_CHANNELS * RX_DEPTH;
    localparam int TX_MEM_D  = NUM_CHANNELS * TX_DEPTH;
    localparam int RX_MEM_AW = (RX_MEM_D > 1) ? $clog2(RX_MEM_D) : 1;
    localparam int TX_MEM_AW = (TX_MEM_D > 1) ? $clog2(TX_MEM_D) : 1;

    // Sequencer states: idle takes a request, data streams popped bytes.
    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_DATA = 1'b1;

    logic [0:0]                           r_state;
    logic [0:0]                           n_state;
    logic [mcur_pkg::COUNT_W-1:0]         r_left;
    logic [mcur_pkg::COUNT_W-1:0]         n_left;
    logic [CW-1:0]                        r_ch;
    logic                                 r_is_tx;

    // Output register.
    logic                                 r_o_valid;
    logic [mcur_pkg::STATUS_W-1:0]        r_o_status;
    logic [mcur_pkg::DATA_W-1:0]          r_o_data;
    logic                                 r_o_dvalid;
    logic                                 r_o_last;
    logic [mcur_pkg::LEVEL_W-1:0]         r_o_rxl;
    logic [mcur_pkg::LEVEL_W-1:0]         r_o_txl;

    logic                                 out_load;
    logic [mcur_pkg::STATUS_W-1:0]        n_o_status;
    logic [mcur_pkg::DATA_W-1:0]          n_o_data;
    logic                                 n_o_dvalid;
    logic                                 n_o_last;
    logic [mcur_pkg::LEVEL_W-1:0]         n_o_rxl;
    logic [mcur_pkg::LEVEL_W-1:0]         n_o_txl;

    logic                                 out_free;
    logic                                 accept;
    logic                                 ch_in_ok;
    logic [CW-1:0]                        ch_in_idx;
    logic [CW-1:0]                        ch_sel;
    logic                                 fin;

    logic                                 rx_push;
    logic                                 rx_pop;
    logic                                 tx_push;
    logic                                 tx_pop;
    logic [RX_AW-1:0]                     rx_head_nxt;
    logic [RX_AW-1:0]                     rx_tail_nxt;
    logic [TX_AW-1:0]                     tx_head_nxt;
    logic [TX_AW-1:0]                     tx_tail_nxt;
    mcur_pkg::t_ring_stat                 rx_stat;
    mcur_pkg::t_ring_stat                 tx_stat;
    logic [mcur_pkg::DATA_W-1:0]          rx_rd_data;
    logic [mcur_pkg::DATA_W-1:0]          tx_rd_data;

    // Handshake: take a request only when idle and the output register frees up.
    assign out_free    = !r_o_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && out_free;
    assign accept      = i_req.valid && i_req.ready;

    // Channel check; drive index zero for a rejected channel so the banks
    // never see an out-of-range entry.
    assign ch_in_ok  = (int'(i_req.channel) < NUM_CHANNELS);
    assign ch_in_idx = ch_in_ok ? CW'(i_req.channel) : '0;
    assign ch_sel    = (r_state == S_IDLE) ? ch_in_idx : r_ch;

    mcur_ring_ptrs #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .DEPTH        (RX_DEPTH)
    ) u_rx_ptrs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ch       (ch_sel),
        .i_push     (rx_push),
        .i_pop      (rx_pop),
        .o_head_nxt (rx_head_nxt),
        .o_tail_nxt (rx_tail_nxt),
        .o_stat     (rx_stat)
    );

    mcur_ring_ptrs #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .DEPTH        (TX_DEPTH)
    ) u_tx_ptrs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ch       (ch_sel),
        .i_push     (tx_push),
        .i_pop      (tx_pop),
        .o_head_nxt (tx_head_nxt),
        .o_tail_nxt (tx_tail_nxt),
        .o_stat     (tx_stat)
    );

    // Byte stores: channel in the upper address bits, slot in the lower.
    // Only one ring access is in flight at a time, so a read never meets a
    // write to the same entry and no forwarding is needed.
    mcur_ram #(
        .WIDTH (mcur_pkg::DATA_W),
        .DEPTH (RX_MEM_D)
    ) u_rx_store (
        .i_clk     (i_clk),
        .i_wr_en   (rx_push),
        .i_wr_addr (RX_MEM_AW'({ch_sel, rx_head_nxt})),
        .i_wr_data (i_req.data_in),
        .i_rd_en   (rx_pop),
        .i_rd_addr (RX_MEM_AW'({ch_sel, rx_tail_nxt})),
        .o_rd_data (rx_rd_data)
    );

    mcur_ram #(
        .WIDTH (mcur_pkg::DATA_W),
        .DEPTH (TX_MEM_D)
    ) u_tx_store (
        .i_clk     (i_clk),
        .i_wr_en   (tx_push),
        .i_wr_addr (TX_MEM_AW'({ch_sel, tx_head_nxt})),
        .i_wr_data (i_req.data_in),
        .i_rd_en   (tx_pop),
        .i_rd_addr (TX_MEM_AW'({ch_sel, tx_tail_nxt})),
        .o_rd_data (tx_rd_data)
    );

    // Sequencer and result composition.
    always_comb begin
        n_state    = r_state;
        n_left     = r_left;
        rx_push    = 1'b0;
        rx_pop     = 1'b0;
        tx_push    = 1'b0;
        tx_pop     = 1'b0;
        out_load   = 1'b0;
        fin        = 1'b0;
        n_o_status = mcur_pkg::ST_OK;
        n_o_data   = '0;
        n_o_dvalid = 1'b0;
        n_o_last   = 1'b1;
        n_o_rxl    = rx_stat.level;
        n_o_txl    = tx_stat.level;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!ch_in_ok) begin
                        // reject: zero levels, no state change
                        out_load   = 1'b1;
                        n_o_status = mcur_pkg::ST_BAD_CH;
                        n_o_rxl    = '0;
                        n_o_txl    = '0;
                    end else begin
                        unique case (i_req.req_type)
                            mcur_pkg::REQ_LINE_RX: begin
                                out_load = 1'b1;
                                if (rx_stat.full) begin
                                    n_o_status = mcur_pkg::ST_FULL;  // drop the byte
                                end else begin
                                    rx_push = 1'b1;
                                    n_o_rxl = rx_stat.level_inc;
                                end
                            end
                            mcur_pkg::REQ_HOST_WR: begin
                                out_load = 1'b1;
                                if (tx_stat.full) begin
                                    n_o_status = mcur_pkg::ST_FULL;
                                end else begin
                                    tx_push = 1'b1;
                                    n_o_txl = tx_stat.level_inc;
                                end
                            end
                            mcur_pkg::REQ_HOST_RD: begin
                                if (i_req.count == '0) begin
                                    out_load = 1'b1;
                                end else if (rx_stat.empty) begin
                                    out_load   = 1'b1;
                                    n_o_status = mcur_pkg::ST_EMPTY;
                                end else begin
                                    // start the burst: pop the first byte
                                    rx_pop  = 1'b1;
                                    n_left  = i_req.count;
                                    n_state = S_DATA;
                                end
                            end
                            mcur_pkg::REQ_TX_READY: begin
                                if (tx_stat.empty) begin
                                    out_load   = 1'b1;
                                    n_o_status = mcur_pkg::ST_EMPTY;
                                end else begin
                                    tx_pop  = 1'b1;
                                    n_left  = mcur_pkg::COUNT_W'(1);
                                    n_state = S_DATA;
                                end
                            end
                            default: begin
                                // level query and unused codes
                                out_load = 1'b1;
                            end
                        endcase
                    end
                end
            end
            S_DATA: begin
                // the most recently read byte waits in the RAM output register
                if (out_free) begin
                    fin        = (r_left == mcur_pkg::COUNT_W'(1)) ||
                                 (r_is_tx ? tx_stat.empty : rx_stat.empty);
                    out_load   = 1'b1;
                    n_o_data   = r_is_tx ? tx_rd_data : rx_rd_data;
                    n_o_dvalid = 1'b1;
                    n_o_last   = fin;
                    if (fin) begin
                        n_state = S_IDLE;
                    end else begin
                        // advance the burst: pop the next receive byte
                        rx_pop = 1'b1;
                        n_left = r_left - mcur_pkg::COUNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_left    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_left    <= n_left;
            r_o_valid <= out_load || (r_o_valid && !o_rsp.ready);
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ch    <= ch_in_idx;
            r_is_tx <= (i_req.req_type == mcur_pkg::REQ_TX_READY);
        end
        if (out_load) begin
            r_o_status <= n_o_status;
            r_o_data   <= n_o_data;
            r_o_dvalid <= n_o_dvalid;
            r_o_last   <= n_o_last;
            r_o_rxl    <= n_o_rxl;
            r_o_txl    <= n_o_txl;
        end
    end

    assign o_rsp.valid      = r_o_valid;
    assign o_rsp.status     = r_o_status;
    assign o_rsp.data_out   = r_o_data;
    assign o_rsp.data_valid = r_o_dvalid;
    assign o_rsp.last       = r_o_last;
    assign o_rsp.rx_level   = r_o_rxl;
    assign o_rsp.tx_level   = r_o_txl;

endmodule
